// File: rtl/assert_macros.svh
// assertion macros used by the framer top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define AST_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, disabled while in reset
`define AST_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: rtl/pacf_pkg.sv
// types and constants of the paced audio command framer
package pacf_pkg;

    localparam int FUNC_W    = 2;
    localparam int CODE_W    = 8;
    localparam int PARAM_W   = 16;
    localparam int TIME_W    = 32;
    localparam int BYTE_W    = 8;
    localparam int ENTRY_W   = CODE_W + PARAM_W;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 16;
    localparam int FRAME_LEN = 10;
    localparam int IDX_W     = 4;

    localparam logic [FUNC_W-1:0] FN_ENQ  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_TICK = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP    = 1'b1;

    localparam logic [CODE_W-1:0]    VOLUME_CMD    = 8'h06;
    localparam logic                 ENABLE_RST    = 1'b1;
    localparam logic [CFG_DAT_W-1:0] GAP_RST       = 16'd100;

    localparam logic [BYTE_W-1:0] BYTE_START = 8'h7E;
    localparam logic [BYTE_W-1:0] BYTE_VER   = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_LEN   = 8'h06;
    localparam logic [BYTE_W-1:0] BYTE_FB    = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_END   = 8'hEF;

    localparam logic [IDX_W-1:0] IDX_START = 4'd0;
    localparam logic [IDX_W-1:0] IDX_VER   = 4'd1;
    localparam logic [IDX_W-1:0] IDX_LEN   = 4'd2;
    localparam logic [IDX_W-1:0] IDX_CMD   = 4'd3;
    localparam logic [IDX_W-1:0] IDX_FB    = 4'd4;
    localparam logic [IDX_W-1:0] IDX_HI    = 4'd5;
    localparam logic [IDX_W-1:0] IDX_LO    = 4'd6;
    localparam logic [IDX_W-1:0] IDX_CKHI  = 4'd7;
    localparam logic [IDX_W-1:0] IDX_CKLO  = 4'd8;
    localparam logic [IDX_W-1:0] IDX_LAST  = 4'(FRAME_LEN - 1);

    typedef struct packed {
        logic [CODE_W-1:0]  code;
        logic [PARAM_W-1:0] param;
    } t_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SEND
    } t_state;

endpackage

// File: rtl/pacf_in_if.sv
// command word channel
interface pacf_in_if;
    import pacf_pkg::*;

    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [CODE_W-1:0]   cmd_code;
    logic [PARAM_W-1:0]  cmd_param;
    logic [TIME_W-1:0]   now_ms;

    modport source (output valid, func, cmd_code, cmd_param, now_ms, input ready);
    modport sink   (input valid, func, cmd_code, cmd_param, now_ms, output ready);
endinterface

// File: rtl/pacf_out_if.sv
// frame byte word channel
interface pacf_out_if;
    import pacf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] frame_byte;
    logic              frame_last;

    modport source (output valid, frame_byte, frame_last, input ready);
    modport sink   (input valid, frame_byte, frame_last, output ready);
endinterface

// File: rtl/pacf_store.sv
// command queue storage, one write and one registered read per cycle
module pacf_store #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic [pacf_pkg::ENTRY_W-1:0] i_wdata,
    input  logic                    i_re,
    input  logic [AW-1:0]           i_raddr,
    output logic [pacf_pkg::ENTRY_W-1:0] o_rdata
);
    import pacf_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];
    logic [ENTRY_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/pacf_frame.sv
// ten-byte frame builder and output register
module pacf_frame (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  pacf_pkg::t_entry i_entry,
    output logic             o_busy,
    pacf_out_if.source       o_frame
);
    import pacf_pkg::*;

    logic [CODE_W-1:0]  r_cmd;
    logic [BYTE_W-1:0]  r_hi;
    logic [BYTE_W-1:0]  r_lo;
    logic [PARAM_W-1:0] r_ck;
    logic [IDX_W-1:0]   r_idx;
    logic               r_valid;
    logic [BYTE_W-1:0]  r_byte;
    logic               r_last;

    logic [PARAM_W-1:0] w_sum;
    logic [IDX_W-1:0]   w_idx_nx;
    logic               w_take;

    function automatic logic [BYTE_W-1:0] frame_byte_at(
        input logic [IDX_W-1:0]   idx,
        input logic [CODE_W-1:0]  cmd,
        input logic [BYTE_W-1:0]  hi,
        input logic [BYTE_W-1:0]  lo,
        input logic [PARAM_W-1:0] ck
    );
        logic [BYTE_W-1:0] b;
        unique case (idx)
            IDX_START: b = BYTE_START;
            IDX_VER:   b = BYTE_VER;
            IDX_LEN:   b = BYTE_LEN;
            IDX_CMD:   b = cmd;
            IDX_FB:    b = BYTE_FB;
            IDX_HI:    b = hi;
            IDX_LO:    b = lo;
            IDX_CKHI:  b = ck[15:8];
            IDX_CKLO:  b = ck[7:0];
            default:   b = BYTE_END;
        endcase
        return b;
    endfunction

    // checksum sum over version, length, command and parameter bytes
    assign w_sum = PARAM_W'(BYTE_VER) + PARAM_W'(BYTE_LEN) + PARAM_W'(i_entry.code)
                 + PARAM_W'(i_entry.param[15:8]) + PARAM_W'(i_entry.param[7:0]);
    assign w_idx_nx = r_idx + IDX_W'(1);
    assign w_take   = r_valid && o_frame.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= IDX_START;
        end else if (i_load) begin
            r_valid <= 1'b1;
            r_idx   <= IDX_START;
        end else if (w_take) begin
            if (r_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= w_idx_nx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_cmd  <= i_entry.code;
            r_hi   <= i_entry.param[15:8];
            r_lo   <= i_entry.param[7:0];
            r_ck   <= PARAM_W'(0) - w_sum;
            r_byte <= BYTE_START;
            r_last <= 1'b0;
        end else if (w_take && !r_last) begin
            r_byte <= frame_byte_at(w_idx_nx, r_cmd, r_hi, r_lo, r_ck);
            r_last <= (w_idx_nx == IDX_LAST);
        end
    end

    assign o_busy           = r_valid;
    assign o_frame.valid      = r_valid;
    assign o_frame.frame_byte = r_byte;
    assign o_frame.frame_last = r_last;
endmodule

// File: rtl/paced_audio_command_framer.sv
// paced audio command framer top level: queue control, pacing and configuration
//
// Input channel i_cmd carries one word per operation: func selects enqueue,
// service tick or clear, with cmd_code/cmd_param for enqueue and now_ms for tick.
// Output channel o_frame returns frame bytes, frame_last marking the end byte.
// Enqueue and clear leave the state idle, so i_cmd.ready stays high. A tick
// that sends reads the oldest entry from the queue memory into the store's
// read register, then the frame register loads the first of ten frame bytes,
// and one byte leaves per cycle while o_frame.ready is high. Once the last
// byte is accepted, the frame goes idle, the state returns to idle and the
// next word is taken. A tick that does not send leaves the state idle. While
// the receiver stalls, the current byte holds and i_cmd.ready stays low.
// The user must write configuration (i_cfg_*) only while idle (not enforced).
// Synchronous reset empties the queue, zeroes the last-send time, enables the
// player and sets the gap to 100 ms; queue memory contents stay undefined.
`include "assert_macros.svh"

module paced_audio_command_framer #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pacf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pacf_pkg::CFG_DAT_W-1:0]  i_cfg_data,
    pacf_in_if.sink                         i_cmd,
    pacf_out_if.source                      o_frame
);
    import pacf_pkg::*;

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [CW-1:0]      r_count;
    logic [TIME_W-1:0]  r_last_send;
    logic               r_enabled;
    logic [CFG_DAT_W-1:0] r_gap;

    logic               w_acc;
    logic               w_enq;
    logic               w_clr;
    logic               w_fire;
    logic               w_full;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_load;
    logic               w_busy;
    logic               w_re;
    t_entry             w_wentry;
    t_entry             w_rentry;

    function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
        return (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    assign w_acc     = i_cmd.valid && i_cmd.ready;
    assign w_full    = (r_count == CW'(QUEUE_DEPTH));
    assign w_elapsed = i_cmd.now_ms - r_last_send;
    assign w_enq     = w_acc && (i_cmd.func == FN_ENQ)
                     && (r_enabled || (i_cmd.cmd_code == VOLUME_CMD));
    assign w_clr     = w_acc && (i_cmd.func == FN_CLR);
    assign w_fire    = w_acc && (i_cmd.func == FN_TICK) && (r_count != '0)
                     && (w_elapsed >= TIME_W'(r_gap));
    assign w_wentry  = '{code: i_cmd.cmd_code, param: i_cmd.cmd_param};

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_SEND;
            ST_SEND: begin
                if (!w_busy) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        i_cmd.ready = 1'b0;
        w_load      = 1'b0;
        w_re        = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                i_cmd.ready = 1'b1;
                w_re        = w_fire;
            end
            ST_READ: w_load = 1'b1;
            ST_SEND: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
            r_last_send <= '0;
        end else if (w_clr) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else if (w_enq) begin
            r_wr_ptr <= advance(r_wr_ptr);
            if (w_full) begin
                r_rd_ptr <= advance(r_rd_ptr);
            end else begin
                r_count <= r_count + CW'(1);
            end
        end else if (w_fire) begin
            r_rd_ptr    <= advance(r_rd_ptr);
            r_count     <= r_count - CW'(1);
            r_last_send <= i_cmd.now_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= ENABLE_RST;
            r_gap     <= GAP_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ENABLE: r_enabled <= i_cfg_data[0];
                CFG_GAP:    r_gap     <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    pacf_store #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_enq),
        .i_waddr (r_wr_ptr),
        .i_wdata (w_wentry),
        .i_re    (w_re),
        .i_raddr (r_rd_ptr),
        .o_rdata (w_rentry)
    );

    pacf_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_entry (w_rentry),
        .o_busy  (w_busy),
        .o_frame (o_frame)
    );

    `AST_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(QUEUE_DEPTH))
    `AST_SAME(a_rd_ptr_range, i_clk, i_rst_n, 1'b1, r_rd_ptr <= AW'(QUEUE_DEPTH - 1))
    `AST_NEXT(a_read_loads, i_clk, i_rst_n, r_state == ST_READ, w_busy)
    `AST_SAME(a_valid_in_send, i_clk, i_rst_n, o_frame.valid, r_state == ST_SEND && !i_cmd.ready)
endmodule
